// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk_s, rstn_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk_s, rstn_s, expr) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk_s, rstn_s, prop)
`define ASSERT_NEVER(label, clk_s, rstn_s, expr)

`endif

`endif

// ===== hw/rtl/ggbi_pkg.sv =====
package ggbi_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // field widths
  localparam int PIX_W   = 16;
  localparam int GRAY_W  = 5;
  localparam int WGT_W   = 8;
  localparam int FW_W    = 10;
  localparam int FH_W    = 11;
  localparam int SUM3_W  = 7;
  localparam int TAP4_W  = 7;
  localparam int PROD_W  = WGT_W + TAP4_W;
  localparam int PRODC_W = WGT_W + GRAY_W;
  localparam int BSUM_W  = PROD_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BLUR_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WGT_CORNER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WGT_EDGE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WGT_CENTER = 3'd6;

  // register reset values
  localparam logic [FW_W-1:0]  RST_FRAME_W    = 10'd320;
  localparam logic [FH_W-1:0]  RST_FRAME_H    = 11'd240;
  localparam logic [WGT_W-1:0] RST_WGT_CORNER = 8'd3;
  localparam logic [WGT_W-1:0] RST_WGT_EDGE   = 8'd20;
  localparam logic [WGT_W-1:0] RST_WGT_CENTER = 8'd164;

  // line memory holds {upper line, middle line} per column
  localparam int LINE_W = 2 * GRAY_W;

  // output queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = OQ_AW + 1;

  // reciprocal of three in 9 fractional bits, exact for sums up to 93
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;
  localparam int DIV3_W     = SUM3_W + 8;

  localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             run_end;
    logic             frame_end;
  } result_t;

  // rgb565-style word to 5-bit gray level
  function automatic logic [GRAY_W-1:0] gray_of(logic [PIX_W-1:0] p);
    logic [SUM3_W-1:0] s;
    logic [DIV3_W-1:0] m;
    s = SUM3_W'(p[4:0]) + SUM3_W'(p[10:6]) + SUM3_W'(p[15:11]);
    m = DIV3_W'(s) * DIV3_W'(DIV3_MUL);
    return m[DIV3_SHIFT +: GRAY_W];
  endfunction

  // gray level copied into all three color fields
  function automatic logic [PIX_W-1:0] pack_gray(logic [GRAY_W-1:0] g);
    return {g, g, 1'b0, g};
  endfunction

  function automatic logic [COL_W:0] clamp_width(logic [FW_W-1:0] v);
    logic [COL_W:0] r;
    if (v < FW_W'(3)) begin
      r = (COL_W+1)'(3);
    end else if (v > FW_W'(MAX_WIDTH)) begin
      r = (COL_W+1)'(MAX_WIDTH);
    end else begin
      r = (COL_W+1)'(v);
    end
    return r;
  endfunction

  function automatic logic [ROW_W:0] clamp_height(logic [FH_W-1:0] v);
    logic [ROW_W:0] r;
    if (v < FH_W'(3)) begin
      r = (ROW_W+1)'(3);
    end else if (v > FH_W'(MAX_HEIGHT)) begin
      r = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      r = (ROW_W+1)'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ggbi_ram.sv =====
module ggbi_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/gray_gaussian_blur_invert_top.sv =====
// Streaming gray-level 3x3 blur with optional invert. Raster-ordered pixel words
// come in one per clock and are turned into 5-bit gray levels; interior pixels
// may be blurred with programmable Q8 corner/edge/center weights, border pixels
// pass through, and the result may be inverted. A result for pixel (x-1,y-1)
// leaves when pixel (x,y) arrives, and a pixel in the last column or last row
// also leaves at once, so one input word gives zero, one or two output words.
// The block takes one word per clock with no idle cycles while the output keeps
// up. On the last line of a frame every word but the first gives two results,
// and with only one result leaving per clock input ready drops there to keep
// pace. The line memory is read and written once per word. A word's results
// pass the stage b and stage c registers and are then written into the output
// queue; they are at the output right after that write when the queue is
// empty. The eight-entry output queue absorbs bursts of two results; input
// ready drops only when the queue, counting the words still in the pipeline,
// could not hold two more results. The line memory needs no clearing pass: the
// first two lines of a frame never use its stale entries for a result.
// Configuration must be written only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module gray_gaussian_blur_invert_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [ggbi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ggbi_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ggbi_pkg::PIX_W-1:0]          in_pixel_word,
  input  logic                                in_frame_start,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ggbi_pkg::PIX_W-1:0]          out_pixel_out,
  output logic [ggbi_pkg::COL_W-1:0]          out_col,
  output logic [ggbi_pkg::ROW_W-1:0]          out_row,
  output logic                                out_run_end,
  output logic                                out_frame_end
);

  localparam int COL_W  = ggbi_pkg::COL_W;
  localparam int ROW_W  = ggbi_pkg::ROW_W;
  localparam int GRAY_W = ggbi_pkg::GRAY_W;
  localparam int WGT_W  = ggbi_pkg::WGT_W;
  localparam int OQ_AW  = ggbi_pkg::OQ_AW;
  localparam int OQ_CW  = ggbi_pkg::OQ_CW;

  // ---------------------------------------------------------------------------
  // configuration registers
  logic                         blur_en_r;
  logic                         invert_en_r;
  logic [ggbi_pkg::FW_W-1:0]    frame_w_r;
  logic [ggbi_pkg::FH_W-1:0]    frame_h_r;
  logic [WGT_W-1:0]             wgt_corner_r;
  logic [WGT_W-1:0]             wgt_edge_r;
  logic [WGT_W-1:0]             wgt_center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_en_r    <= 1'b1;
      invert_en_r  <= 1'b1;
      frame_w_r    <= ggbi_pkg::RST_FRAME_W;
      frame_h_r    <= ggbi_pkg::RST_FRAME_H;
      wgt_corner_r <= ggbi_pkg::RST_WGT_CORNER;
      wgt_edge_r   <= ggbi_pkg::RST_WGT_EDGE;
      wgt_center_r <= ggbi_pkg::RST_WGT_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ggbi_pkg::REG_BLUR_EN:    blur_en_r    <= cfg_data[0];
        ggbi_pkg::REG_INVERT_EN:  invert_en_r  <= cfg_data[0];
        ggbi_pkg::REG_FRAME_W:    frame_w_r    <= cfg_data[ggbi_pkg::FW_W-1:0];
        ggbi_pkg::REG_FRAME_H:    frame_h_r    <= cfg_data[ggbi_pkg::FH_W-1:0];
        ggbi_pkg::REG_WGT_CORNER: wgt_corner_r <= cfg_data[WGT_W-1:0];
        ggbi_pkg::REG_WGT_EDGE:   wgt_edge_r   <= cfg_data[WGT_W-1:0];
        ggbi_pkg::REG_WGT_CENTER: wgt_center_r <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COL_W:0] w_eff;
  logic [ROW_W:0] h_eff;

  assign w_eff = ggbi_pkg::clamp_width(frame_w_r);
  assign h_eff = ggbi_pkg::clamp_height(frame_h_r);

  // ---------------------------------------------------------------------------
  // stage a: position, gray level, line memory read
  logic             accept;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] x_a;
  logic [ROW_W-1:0] y_a;
  logic [ROW_W:0]   row_a;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             last_col_a, last_row_a;
  logic [GRAY_W-1:0] gray_a;

  assign accept = in_valid && in_ready;
  assign gray_a = ggbi_pkg::gray_of(in_pixel_word);

  // wrap a position that lies past the geometry, or restart it at a frame start
  always_comb begin
    x_a   = col_r;
    row_a = {1'b0, row_r};
    if (in_frame_start) begin
      x_a   = '0;
      row_a = '0;
    end else begin
      if ({1'b0, col_r} >= w_eff) begin
        x_a   = '0;
        row_a = {1'b0, row_r} + 1'b1;
      end
      if (row_a >= h_eff) begin
        row_a = '0;
      end
    end
    y_a = row_a[ROW_W-1:0];
  end

  // position of the next word
  always_comb begin
    col_inc = {1'b0, x_a} + 1'b1;
    row_inc = {1'b0, y_a} + 1'b1;
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = y_a;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  assign last_col_a = ({1'b0, x_a} == (w_eff - 1'b1));
  assign last_row_a = ({1'b0, y_a} == (h_eff - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b registers
  logic              vb_r;
  logic [COL_W-1:0]  xb_r;
  logic [ROW_W-1:0]  yb_r;
  logic [GRAY_W-1:0] grayb_r;
  logic              dlyb_r, blurb_r, selfb_r, fendb_r;
  logic              fwd_hit_r;
  logic [ggbi_pkg::LINE_W-1:0] fwd_data_r;
  logic [ggbi_pkg::LINE_W-1:0] ram_rdata;
  logic [ggbi_pkg::LINE_W-1:0] ram_wdata;
  logic [GRAY_W-1:0] top_b, mid_b;

  // write data of the word now in stage b
  assign ram_wdata = {mid_b, grayb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r      <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      vb_r      <= accept;
      fwd_hit_r <= accept && vb_r && (xb_r == x_a);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xb_r       <= x_a;
      yb_r       <= y_a;
      grayb_r    <= gray_a;
      dlyb_r     <= (x_a != '0) && (y_a != '0);
      blurb_r    <= blur_en_r && (x_a >= COL_W'(2)) && (y_a >= ROW_W'(2));
      selfb_r    <= last_col_a || last_row_a;
      fendb_r    <= last_col_a && last_row_a;
      fwd_data_r <= ram_wdata;
    end
  end

  // line memory: {upper, middle} gray levels per column
  ggbi_ram #(
    .WIDTH (ggbi_pkg::LINE_W),
    .DEPTH (ggbi_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (vb_r),
    .waddr (xb_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (x_a),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage b: forward a same-column write, window shift, weight products
  logic [GRAY_W-1:0] win_r [6];
  logic [ggbi_pkg::TAP4_W-1:0] corners_b, edges_b;

  always_comb begin
    if (fwd_hit_r) begin
      top_b = fwd_data_r[GRAY_W +: GRAY_W];
      mid_b = fwd_data_r[0 +: GRAY_W];
    end else begin
      top_b = ram_rdata[GRAY_W +: GRAY_W];
      mid_b = ram_rdata[0 +: GRAY_W];
    end
  end

  assign corners_b = ggbi_pkg::TAP4_W'(win_r[0]) + ggbi_pkg::TAP4_W'(win_r[2])
                   + ggbi_pkg::TAP4_W'(top_b) + ggbi_pkg::TAP4_W'(grayb_r);
  assign edges_b   = ggbi_pkg::TAP4_W'(win_r[1]) + ggbi_pkg::TAP4_W'(win_r[3])
                   + ggbi_pkg::TAP4_W'(win_r[5]) + ggbi_pkg::TAP4_W'(mid_b);

  // window holds the two previous columns, top/mid/bottom each
  always_ff @(posedge clk) begin
    if (vb_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_b;
      win_r[4] <= mid_b;
      win_r[5] <= grayb_r;
    end
  end

  logic                          vc_r;
  logic [ggbi_pkg::PROD_W-1:0]   pc_r, pe_r;
  logic [ggbi_pkg::PRODC_W-1:0]  pm_r;
  logic [GRAY_W-1:0]             passc_r, grayc_r;
  logic [COL_W-1:0]              xc_r;
  logic [ROW_W-1:0]              yc_r;
  logic                          dlyc_r, blurc_r, selfc_r, fendc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vb_r) begin
      pc_r    <= ggbi_pkg::PROD_W'(wgt_corner_r) * ggbi_pkg::PROD_W'(corners_b);
      pe_r    <= ggbi_pkg::PROD_W'(wgt_edge_r) * ggbi_pkg::PROD_W'(edges_b);
      pm_r    <= ggbi_pkg::PRODC_W'(wgt_center_r) * ggbi_pkg::PRODC_W'(win_r[4]);
      passc_r <= win_r[4];
      grayc_r <= grayb_r;
      xc_r    <= xb_r;
      yc_r    <= yb_r;
      dlyc_r  <= dlyb_r;
      blurc_r <= blurb_r;
      selfc_r <= selfb_r;
      fendc_r <= fendb_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: sum, saturate, invert, pack, push into the output queue
  logic [ggbi_pkg::BSUM_W-1:0] bsum_c;
  logic [GRAY_W-1:0]           blur_c, dly_gray_c, dly_out_c, self_out_c;
  ggbi_pkg::result_t           res_dly_c, res_self_c, push0_c;
  logic [1:0]                  push_n;

  assign bsum_c = ggbi_pkg::BSUM_W'(pc_r) + ggbi_pkg::BSUM_W'(pe_r)
                + ggbi_pkg::BSUM_W'(pm_r);
  assign blur_c = (|bsum_c[ggbi_pkg::BSUM_W-1:8+GRAY_W]) ? ggbi_pkg::GRAY_MAX
                                                         : bsum_c[8 +: GRAY_W];
  assign dly_gray_c = blurc_r ? blur_c : passc_r;
  assign dly_out_c  = invert_en_r ? ~dly_gray_c : dly_gray_c;
  assign self_out_c = invert_en_r ? ~grayc_r : grayc_r;

  always_comb begin
    res_dly_c.pixel      = ggbi_pkg::pack_gray(dly_out_c);
    res_dly_c.col        = xc_r - 1'b1;
    res_dly_c.row        = yc_r - 1'b1;
    res_dly_c.run_end    = !selfc_r;
    res_dly_c.frame_end  = 1'b0;
    res_self_c.pixel     = ggbi_pkg::pack_gray(self_out_c);
    res_self_c.col       = xc_r;
    res_self_c.row       = yc_r;
    res_self_c.run_end   = 1'b1;
    res_self_c.frame_end = fendc_r;
    push0_c = dlyc_r ? res_dly_c : res_self_c;
    push_n  = vc_r ? (2'({1'b0, dlyc_r}) + 2'({1'b0, selfc_r})) : 2'd0;
  end

  // ---------------------------------------------------------------------------
  // output queue
  ggbi_pkg::result_t oq_r [ggbi_pkg::OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_head_r, oq_tail_r;
  logic [OQ_CW-1:0]  oq_cnt_r;
  logic              pop;
  logic [OQ_CW:0]    oq_reserved;

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      oq_r[oq_tail_r] <= push0_c;
    end
    if (push_n == 2'd2) begin
      oq_r[oq_tail_r + 1'b1] <= res_self_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_head_r <= '0;
      oq_tail_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      oq_tail_r <= oq_tail_r + OQ_AW'(push_n);
      oq_head_r <= oq_head_r + OQ_AW'(pop);
      oq_cnt_r  <= oq_cnt_r + OQ_CW'(push_n) - OQ_CW'(pop);
    end
  end

  // room for two results of every word in flight plus the next one
  assign oq_reserved = (OQ_CW+1)'(oq_cnt_r) + (vb_r ? (OQ_CW+1)'(2) : '0)
                     + (vc_r ? (OQ_CW+1)'(2) : '0);
  assign in_ready = (oq_reserved <= (OQ_CW+1)'(ggbi_pkg::OQ_DEPTH - 2));

  assign out_valid     = (oq_cnt_r != '0);
  assign out_pixel_out = oq_r[oq_head_r].pixel;
  assign out_col       = oq_r[oq_head_r].col;
  assign out_row       = oq_r[oq_head_r].row;
  assign out_run_end   = oq_r[oq_head_r].run_end;
  assign out_frame_end = oq_r[oq_head_r].frame_end;

  // ---------------------------------------------------------------------------
  // assertions
  `ASSERT_PROP(a_oq_bound, clk, rst_n, oq_cnt_r <= OQ_CW'(ggbi_pkg::OQ_DEPTH))
  `ASSERT_NEVER(a_oq_overflow, clk, rst_n, (OQ_CW+1)'(oq_cnt_r) + (OQ_CW+1)'(push_n) > (OQ_CW+1)'(ggbi_pkg::OQ_DEPTH))
  `ASSERT_PROP(a_accept_to_b, clk, rst_n, accept |=> vb_r)
  `ASSERT_PROP(a_b_to_c, clk, rst_n, vb_r |=> vc_r)
  `ASSERT_NEVER(a_fwd_without_word, clk, rst_n, fwd_hit_r && !vb_r)

endmodule

// ===== dv/gray_gaussian_blur_invert_top_tb.sv =====
module gray_gaussian_blur_invert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W      = ggbi_pkg::PIX_W;
  localparam int GRAY_W     = ggbi_pkg::GRAY_W;
  localparam int COL_W      = ggbi_pkg::COL_W;
  localparam int ROW_W      = ggbi_pkg::ROW_W;
  localparam int CFG_IDX_W  = ggbi_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ggbi_pkg::CFG_DATA_W;
  localparam int FW_W       = ggbi_pkg::FW_W;
  localparam int FH_W       = ggbi_pkg::FH_W;
  localparam int WGT_W      = ggbi_pkg::WGT_W;
  localparam int MAX_WIDTH  = ggbi_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = ggbi_pkg::MAX_HEIGHT;

  localparam int IDLE_PCT     = 34;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_COL     = 45;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 14;
  localparam int SMALL_BUDGET = 10;
  localparam int WIDE_EXTRA   = 70;
  localparam int CLAMP_ITEMS  = 40;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             start;
  } pixel_item_t;

  typedef struct {
    bit          blur;
    bit          invert;
    int unsigned width;
    int unsigned height;
    int unsigned corner;
    int unsigned side;
    int unsigned center;
  } blur_setup_t;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_word = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic [COL_W-1:0]      out_col;
  logic [ROW_W-1:0]      out_row;
  logic                  out_run_end;
  logic                  out_frame_end;

  // stimulus and expectation stores
  pixel_item_t       pixel_backlog[$];
  pixel_item_t       next_word;
  ggbi_pkg::result_t words_due[$];
  ggbi_pkg::result_t want;

  // mirror of the register file
  bit          blur_on = 1'b1;
  bit          invert_on = 1'b1;
  int unsigned frame_w_reg = ggbi_pkg::RST_FRAME_W;
  int unsigned frame_h_reg = ggbi_pkg::RST_FRAME_H;
  int unsigned wgt_corner = ggbi_pkg::RST_WGT_CORNER;
  int unsigned wgt_side = ggbi_pkg::RST_WGT_EDGE;
  int unsigned wgt_center = ggbi_pkg::RST_WGT_CENTER;

  // mirror of position, line stores and 3x3 window
  int               pos_col = 0;
  int               pos_row = 0;
  logic [GRAY_W-1:0] upper_line [MAX_WIDTH];
  logic [GRAY_W-1:0] middle_line [MAX_WIDTH];
  bit               upper_ok [MAX_WIDTH];
  bit               middle_ok [MAX_WIDTH];
  logic [GRAY_W-1:0] win [6];

  // run control
  bit steady = 1'b0;
  bit long_hold_done = 1'b0;
  int rx_hold = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;

  gray_gaussian_blur_invert_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_word (in_pixel_word),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_run_end   (out_run_end),
    .out_frame_end (out_frame_end)
  );

  always #1 clk = ~clk;

  // geometry register clamped to the supported range
  function automatic int eff_dim(input int unsigned v, input int unsigned hi);
    if (v < 3) begin
      return 3;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // gray level packed into all three color fields, inverted if enabled
  function automatic ggbi_pkg::result_t shade_word(input logic [GRAY_W-1:0] g,
                                                   input int col, input int row,
                                                   input bit fend);
    ggbi_pkg::result_t r;
    logic [GRAY_W-1:0] v;
    v = invert_on ? ggbi_pkg::GRAY_MAX - g : g;
    r.pixel = PIX_W'(v) | (PIX_W'(v) << 6) | (PIX_W'(v) << 11);
    r.col = COL_W'(col);
    r.row = ROW_W'(row);
    r.run_end = 1'b0;
    r.frame_end = fend;
    return r;
  endfunction

  // advance the blur pipeline by one pixel word and queue the words it releases
  task automatic predict_gray_blur(input logic [PIX_W-1:0] pix, input logic start);
    int w, h, x, y, n, acc, corners, sides, v;
    logic [GRAY_W-1:0] gray, top, mid;
    ggbi_pkg::result_t res [2];
    w = eff_dim(frame_w_reg, MAX_WIDTH);
    h = eff_dim(frame_h_reg, MAX_HEIGHT);
    if (start) begin
      pos_col = 0;
      pos_row = 0;
    end else begin
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
      end
      if (pos_row >= h) begin
        pos_row = 0;
      end
    end
    x = pos_col;
    y = pos_row;
    gray = GRAY_W'((int'(pix[4:0]) + int'(pix[10:6]) + int'(pix[15:11])) / 3);
    top = upper_line[x];
    mid = middle_line[x];
    n = 0;

    // pixel up and left of this one now has its full neighborhood
    if (x >= 1 && y >= 1) begin
      v = win[4];
      if (blur_on && x >= 2 && y >= 2) begin
        corners = win[0] + win[2] + top + gray;
        sides = win[1] + win[3] + win[5] + mid;
        acc = wgt_corner * corners + wgt_side * sides + wgt_center * win[4];
        v = acc >> 8;
        if (v > int'(ggbi_pkg::GRAY_MAX)) begin
          v = ggbi_pkg::GRAY_MAX;
        end
      end
      res[n] = shade_word(GRAY_W'(v), x - 1, y - 1, 1'b0);
      n++;
    end
    // last column or last row leaves at once, unblurred
    if (x == w - 1 || y == h - 1) begin
      res[n] = shade_word(gray, x, y, x == w - 1 && y == h - 1);
      n++;
    end

    // shift window and update line stores
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = gray;
    upper_line[x] = mid;
    middle_line[x] = gray;
    upper_ok[x] = middle_ok[x];
    middle_ok[x] = 1'b1;

    pos_col = x + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = y + 1;
      if (pos_row >= h) begin
        pos_row = 0;
      end
    end

    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        res[i].run_end = 1'b1;
      end
      words_due.push_back(res[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    mismatches++;
    $display("[%0t] word %0d: %s got 0x%0h, expected 0x%0h", $realtime, results_seen,
             what, got, exp_val);
  endtask

  // one register write per clock, write enable left high for the caller to lower
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    case (idx)
      ggbi_pkg::REG_BLUR_EN:    blur_on = data[0];
      ggbi_pkg::REG_INVERT_EN:  invert_on = data[0];
      ggbi_pkg::REG_FRAME_W:    frame_w_reg = data & ((1 << FW_W) - 1);
      ggbi_pkg::REG_FRAME_H:    frame_h_reg = data & ((1 << FH_W) - 1);
      ggbi_pkg::REG_WGT_CORNER: wgt_corner = data & ((1 << WGT_W) - 1);
      ggbi_pkg::REG_WGT_EDGE:   wgt_side = data & ((1 << WGT_W) - 1);
      ggbi_pkg::REG_WGT_CENTER: wgt_center = data & ((1 << WGT_W) - 1);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setup(input blur_setup_t s);
    @(posedge clk);
    put_reg(ggbi_pkg::REG_BLUR_EN, s.blur);
    put_reg(ggbi_pkg::REG_INVERT_EN, s.invert);
    put_reg(ggbi_pkg::REG_FRAME_W, s.width);
    put_reg(ggbi_pkg::REG_FRAME_H, s.height);
    put_reg(ggbi_pkg::REG_WGT_CORNER, s.corner);
    put_reg(ggbi_pkg::REG_WGT_EDGE, s.side);
    put_reg(ggbi_pkg::REG_WGT_CENTER, s.center);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(input logic [PIX_W-1:0] pix, input logic start);
    pixel_item_t item;
    item.pix = pix;
    item.start = start;
    pixel_backlog.push_back(item);
  endtask

  // random pixels, biased toward the field extremes
  task automatic queue_frame(input int count, input bit start);
    logic [PIX_W-1:0] pix;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0: pix = '0;
        1: pix = '1;
        2: pix = 16'hFFDF;
        default: pix = PIX_W'($urandom);
      endcase
      push_word(pix, (i == 0) ? start : 1'b0);
    end
  endtask

  function automatic int unsigned pick_weight();
    case ($urandom_range(5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // sender stops, then everything in flight drains out
  task automatic wait_quiet();
    do begin
      @(negedge clk);
    end while (pixel_backlog.size() != 0 || in_valid || words_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_gray_blur(in_pixel_word, in_frame_start);
      end
      if (!in_valid || in_ready) begin
        if (pixel_backlog.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_word = pixel_backlog.pop_front();
          in_valid <= 1'b1;
          in_pixel_word <= next_word.pix;
          in_frame_start <= next_word.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          report_mismatch("unexpected word, pixel", out_pixel_out, 0);
        end else begin
          want = words_due.pop_front();
          if (out_pixel_out !== want.pixel) begin
            report_mismatch("pixel", out_pixel_out, want.pixel);
          end
          if (out_col !== want.col) begin
            report_mismatch("col", out_col, want.col);
          end
          if (out_row !== want.row) begin
            report_mismatch("row", out_row, want.row);
          end
          if (out_run_end !== want.run_end) begin
            report_mismatch("run_end", out_run_end, want.run_end);
          end
          if (out_frame_end !== want.frame_end) begin
            report_mismatch("frame_end", out_frame_end, want.frame_end);
          end
          // long back-pressure once, early in the second line of a wide frame
          if (!long_hold_done && want.row == 0 && want.col == HOLD_COL) begin
            long_hold_done = 1'b1;
            rx_hold = LONG_HOLD;
          end
        end
        results_seen++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int ph, count, queued, frame_len, old_w, new_w, new_h, i;
    bit fs, at_origin, cont_ok, started_clean;
    blur_setup_t s;
    logic [PIX_W-1:0] probe [9];

    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
      upper_ok[i] = 1'b0;
      middle_ok[i] = 1'b0;
    end
    for (i = 0; i < 6; i++) begin
      win[i] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame, remaining registers at reset values
    put_reg(ggbi_pkg::REG_FRAME_W, 3);
    put_reg(ggbi_pkg::REG_FRAME_H, 3);
    cfg_we <= 1'b0;
    probe = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07C0, 16'h001F,
              16'h0020, 16'hFFDF, 16'h1234, 16'hFFFF};
    @(negedge clk);
    for (i = 0; i < 9; i++) begin
      push_word(probe[i], i == 0);
    end
    wait_quiet();

    // full weights saturate the blur, next frame follows without a start flag
    s = '{1'b1, 1'b0, 3, 3, 255, 255, 255};
    apply_setup(s);
    probe = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFDF};
    @(negedge clk);
    for (i = 0; i < 9; i++) begin
      push_word(probe[i], 1'b0);
    end
    wait_quiet();

    // geometry below range clamps to 3x3, zero weights, truncated frame
    s = '{1'b1, 1'b1, 0, 2, 0, 0, 0};
    apply_setup(s);
    probe = '{16'h8421, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
              16'h5555, 16'hAAAA, 16'h0000, 16'h0000};
    @(negedge clk);
    for (i = 0; i < 7; i++) begin
      push_word(probe[i], i == 0);
    end
    wait_quiet();

    // random phases, two of them at the widest line
    for (ph = 0; ph < PHASES; ph++) begin
      old_w = eff_dim(frame_w_reg, MAX_WIDTH);
      s.blur = $urandom_range(1);
      s.invert = $urandom_range(1);
      s.corner = pick_weight();
      s.side = pick_weight();
      s.center = pick_weight();
      if (ph == 5) begin
        s.width = MAX_WIDTH;
        s.height = MAX_HEIGHT;
      end else if (ph == 9) begin
        s.width = (1 << FW_W) - 1;
        s.height = (1 << FH_W) - 1;
      end else begin
        case ($urandom_range(7))
          0: s.width = $urandom_range(2, 0);
          1: s.width = 3;
          2: s.width = $urandom_range(40, 11);
          default: s.width = $urandom_range(10, 4);
        endcase
        case ($urandom_range(5))
          0: s.height = $urandom_range(2, 0);
          1: s.height = 3;
          default: s.height = $urandom_range(7, 3);
        endcase
      end
      steady <= (ph >= 2 && ph <= 4);
      apply_setup(s);
      @(negedge clk);
      new_w = eff_dim(s.width, MAX_WIDTH);
      new_h = eff_dim(s.height, MAX_HEIGHT);

      // carry on mid-frame only where every line store entry in use is filled
      at_origin = (pos_col == 0 && pos_row == 0);
      if (at_origin) begin
        fs = $urandom_range(1);
      end else begin
        cont_ok = (new_w <= old_w) && (pos_row >= 2);
        for (i = 0; i < new_w; i++) begin
          if (!upper_ok[i]) begin
            cont_ok = 1'b0;
          end
        end
        fs = cont_ok ? ($urandom_range(2) == 0) : 1'b1;
      end

      if (ph == 5) begin
        queue_frame(MAX_WIDTH + WIDE_EXTRA, 1'b1);
      end else if (ph == 9) begin
        queue_frame(CLAMP_ITEMS, 1'b1);
      end else begin
        queued = 0;
        while (queued < SMALL_BUDGET) begin
          frame_len = new_w * new_h;
          count = ($urandom_range(4) == 0) ? $urandom_range(frame_len - 1, 1) : frame_len;
          started_clean = fs || at_origin;
          queue_frame(count, fs);
          queued += count;
          at_origin = started_clean && (count == frame_len);
          fs = at_origin ? ($urandom_range(3) == 0) : 1'b1;
        end
      end
      wait_quiet();
    end

    steady <= 1'b0;
    repeat (20) @(negedge clk);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== gray_gaussian_blur_invert_top.f =====
+incdir+hw/rtl
hw/rtl/ggbi_pkg.sv
hw/rtl/ggbi_ram.sv
hw/rtl/gray_gaussian_blur_invert_top.sv
dv/gray_gaussian_blur_invert_top_tb.sv
